[design/rc4_counter_mixed_prng_macros.svh]
// ----------------------------------------------------------------------------
// RC4 counter-mixed PRNG assertion macros
// Concurrent assertion shorthands clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RC4_COUNTER_MIXED_PRNG_MACROS_SVH
`define RC4_COUNTER_MIXED_PRNG_MACROS_SVH

// same-cycle implication
`define RC4CM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define RC4CM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

[design/rc4cm_pkg.sv]
// ----------------------------------------------------------------------------
// RC4 counter-mixed PRNG package
// Shared codes and fixed widths of the keystream generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rc4cm_pkg;

    localparam int KEY_W = 64;
    localparam int RES_W = 32;
    localparam int BYTE_W = 8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_GEN  = 1'b1;

    localparam logic [1:0] MODE_KSA  = 2'd0;
    localparam logic [1:0] MODE_DROP = 2'd1;
    localparam logic [1:0] MODE_GEN  = 2'd2;

    localparam int GEN_MIX_STEPS = 8;
    localparam int GEN_STEPS = 12;

    localparam int LCG_MUL = 45;
    localparam int LCG_INC = 1;

endpackage

`default_nettype wire

[design/rc4_counter_mixed_prng.sv]
// ----------------------------------------------------------------------------
// RC4 counter-mixed PRNG
// RC4 keystream with initial drop; each generate word mixes a 64-bit
// counter into j over eight swaps, then yields four keystream bytes.
// ----------------------------------------------------------------------------
// Channel  Signals                                      Dir  Word
// in       i_in_valid / o_in_ready                      in   op, key word, last
// out      o_out_valid / i_out_ready                    out  32-bit keystream
//
// Each swap step runs through states A, B and C on the S-box memory (read i, read j,
// write i; write j rides on the next step's state A): single write port.
// Generate word: 12 steps.
// Final key word: key schedule, then drop; other key words are only stored.
// Reset and rekeying restore the identity S-box at once via valid flags.
// A stalled result sits in the output register; the next word still runs,
// then holds in its last cycle until that register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rc4_counter_mixed_prng #(
    parameter int SBOX_SIZE  = 256,
    parameter int DROP_STEPS = 256
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_operation,
    input  wire logic [rc4cm_pkg::KEY_W-1:0]    i_key_word,
    input  wire logic                           i_key_last,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [rc4cm_pkg::RES_W-1:0]         o_random_word
);

    localparam int IW    = $clog2(SBOX_SIZE);
    localparam int KROWS = (SBOX_SIZE + 7) / 8;
    localparam int KRW   = $clog2(KROWS);
    localparam int CMAX  = (SBOX_SIZE > DROP_STEPS) ? SBOX_SIZE : DROP_STEPS;
    localparam int CW    = $clog2(CMAX + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_A       = 3'd1;
    localparam logic [2:0] S_B       = 3'd2;
    localparam logic [2:0] S_C       = 3'd3;
    localparam logic [2:0] S_FLUSH   = 3'd4;
    localparam logic [2:0] S_COLLECT = 3'd5;
    localparam logic [2:0] S_OUT     = 3'd6;

    function automatic logic [255:0][IW-1:0] build_mod_lut();
        logic [255:0][IW-1:0] lut;
        for (int k = 0; k < 256; k++) begin
            lut[k] = IW'(k % SBOX_SIZE);
        end
        return lut;
    endfunction

    localparam logic [255:0][IW-1:0] MOD_LUT = build_mod_lut();

    function automatic logic [IW-1:0] add_mod(input logic [IW-1:0] a, input logic [IW-1:0] b);
        logic [IW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IW+1)'(SBOX_SIZE)) begin
            s = s - (IW+1)'(SBOX_SIZE);
        end
        return s[IW-1:0];
    endfunction

    function automatic logic [7:0] lcg_next(input logic [7:0] k);
        logic [15:0] p;
        p = 16'(k) * 16'(rc4cm_pkg::LCG_MUL) + 16'(rc4cm_pkg::LCG_INC);
        return p[7:0];
    endfunction

    // S-box and key store
    logic [IW-1:0]              r_sbox [SBOX_SIZE];
    logic [rc4cm_pkg::KEY_W-1:0] r_key_mem [KROWS];
    logic [SBOX_SIZE-1:0]       r_vld;

    logic [2:0]     r_state;
    logic [1:0]     r_mode;
    logic [CW-1:0]  r_cnt;
    logic           r_wpend;
    logic           r_opend;
    logic [IW-1:0]  r_i;
    logic [IW-1:0]  r_j;
    logic [IW-1:0]  r_si;
    logic [IW-1:0]  r_idx;
    logic [63:0]    r_ctr;
    logic [5:0]     r_kcnt;
    logic [8:0]     r_filled;
    logic [7:0]     r_kprev;
    logic [rc4cm_pkg::KEY_W-1:0] r_key_q;
    logic [31:0]    r_res;
    logic [31:0]    r_out;
    logic           r_out_valid;

    // registered read ports with write forwarding and reset-value fallback
    logic [IW-1:0]  r_q0, r_q1, r_a0, r_a1, r_hd0, r_hd1;
    logic           r_v0, r_v1, r_hit0, r_hit1;

    logic           in_acc;
    logic [IW-1:0]  idx_inc;
    logic [IW-1:0]  rd0_data;
    logic [IW-1:0]  rd1_data;
    logic [IW-1:0]  ra0;
    logic           we;
    logic [IW-1:0]  wa;
    logic [IW-1:0]  wd;
    logic [7:0]     key_byte;
    logic [7:0]     ksa_byte;
    logic [7:0]     extra;
    logic [IW-1:0]  j_new;
    logic           step_last;
    logic [5:0]     kcnt_inc;
    logic [8:0]     filled_new;

    assign in_acc        = i_in_valid && o_in_ready;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_random_word = r_out;

    assign idx_inc  = (r_i == IW'(SBOX_SIZE - 1)) ? '0 : r_i + 1'b1;
    assign rd0_data = r_hit0 ? r_hd0 : (r_v0 ? r_q0 : r_a0);
    assign rd1_data = r_hit1 ? r_hd1 : (r_v1 ? r_q1 : r_a1);

    assign key_byte = r_key_q[{r_i[2:0], 3'b000} +: 8];
    assign ksa_byte = (9'(r_i) >= r_filled) ? lcg_next(r_kprev) : key_byte;

    always_comb begin
        extra = 8'd0;
        if (r_mode == rc4cm_pkg::MODE_KSA) begin
            extra = ksa_byte;
        end else if (r_mode == rc4cm_pkg::MODE_GEN
                     && r_cnt < CW'(rc4cm_pkg::GEN_MIX_STEPS)) begin
            extra = r_ctr[{r_cnt[2:0], 3'b000} +: 8];
        end
    end

    assign j_new = add_mod(add_mod(r_j, rd0_data), MOD_LUT[extra]);

    always_comb begin
        unique case (r_mode)
            rc4cm_pkg::MODE_KSA:  step_last = (r_cnt == CW'(SBOX_SIZE - 1));
            rc4cm_pkg::MODE_DROP: step_last = (r_cnt == CW'(DROP_STEPS - 1));
            default:              step_last = (r_cnt == CW'(rc4cm_pkg::GEN_STEPS - 1));
        endcase
    end

    always_comb begin
        ra0 = r_i;
        we  = 1'b0;
        wa  = r_j;
        wd  = r_si;
        unique case (r_state)
            S_A: begin
                ra0 = idx_inc;
                we  = r_wpend;
            end
            S_B: begin
                ra0 = j_new;
            end
            S_C: begin
                we = 1'b1;
                wa = r_i;
                wd = rd0_data;
            end
            S_FLUSH: begin
                we = r_wpend;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    assign kcnt_inc   = (r_kcnt < 6'd63) ? r_kcnt + 6'd1 : r_kcnt;
    assign filled_new = ({kcnt_inc, 3'b000} > 9'(SBOX_SIZE)) ? 9'(SBOX_SIZE)
                                                             : {kcnt_inc, 3'b000};

    // memories and datapath
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_sbox[wa] <= wd;
        end
        r_q0   <= r_sbox[ra0];
        r_q1   <= r_sbox[r_idx];
        r_a0   <= ra0;
        r_a1   <= r_idx;
        r_v0   <= r_vld[ra0];
        r_v1   <= r_vld[r_idx];
        r_hit0 <= we && (wa == ra0);
        r_hit1 <= we && (wa == r_idx);
        r_hd0  <= wd;
        r_hd1  <= wd;
        r_key_q <= r_key_mem[idx_inc[IW-1:3]];

        if (in_acc && i_operation == rc4cm_pkg::OP_LOAD) begin
            if (r_kcnt < 6'(KROWS)) begin
                r_key_mem[r_kcnt[KRW-1:0]] <= i_key_word;
            end
            r_filled <= filled_new;
        end

        unique case (r_state)
            S_B: begin
                r_si <= rd0_data;
                if (r_mode == rc4cm_pkg::MODE_KSA) begin
                    r_kprev <= ksa_byte;
                end
                if (r_opend) begin
                    r_res <= {8'(rd1_data), r_res[31:8]};
                end
            end
            S_C: begin
                r_idx <= add_mod(r_si, rd0_data);
            end
            S_COLLECT: begin
                r_res <= {8'(rd1_data), r_res[31:8]};
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    r_out <= r_res;
                end
            end
            default: begin
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= rc4cm_pkg::MODE_GEN;
            r_cnt       <= '0;
            r_wpend     <= 1'b0;
            r_opend     <= 1'b0;
            r_vld       <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_ctr       <= '0;
            r_kcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (we) begin
                r_vld[wa] <= 1'b1;
            end
            if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_operation == rc4cm_pkg::OP_LOAD) begin
                            if (i_key_last) begin
                                r_vld   <= '0;
                                r_i     <= IW'(SBOX_SIZE - 1);
                                r_j     <= '0;
                                r_ctr   <= '0;
                                r_kcnt  <= '0;
                                r_mode  <= rc4cm_pkg::MODE_KSA;
                                r_cnt   <= '0;
                                r_wpend <= 1'b0;
                                r_opend <= 1'b0;
                                r_state <= S_A;
                            end else begin
                                r_kcnt <= kcnt_inc;
                            end
                        end else begin
                            r_ctr   <= r_ctr + 64'd1;
                            r_mode  <= rc4cm_pkg::MODE_GEN;
                            r_cnt   <= '0;
                            r_wpend <= 1'b0;
                            r_opend <= 1'b0;
                            r_state <= S_A;
                        end
                    end
                end
                S_A: begin
                    r_i     <= idx_inc;
                    r_state <= S_B;
                end
                S_B: begin
                    r_j     <= j_new;
                    r_opend <= 1'b0;
                    r_state <= S_C;
                end
                S_C: begin
                    r_wpend <= 1'b1;
                    r_opend <= (r_mode == rc4cm_pkg::MODE_GEN)
                               && (r_cnt >= CW'(rc4cm_pkg::GEN_MIX_STEPS));
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= step_last ? S_FLUSH : S_A;
                end
                S_FLUSH: begin
                    r_wpend <= 1'b0;
                    if (r_mode == rc4cm_pkg::MODE_KSA) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_cnt   <= '0;
                        r_mode  <= rc4cm_pkg::MODE_DROP;
                        r_state <= (DROP_STEPS > 0) ? S_A : S_IDLE;
                    end else if (r_mode == rc4cm_pkg::MODE_DROP) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_COLLECT;
                    end
                end
                S_COLLECT: begin
                    r_opend <= 1'b0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[design/rc4cm_checker.sv]
// ----------------------------------------------------------------------------
// RC4 counter-mixed PRNG port checker
// Port-level properties of the keystream generator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rc4_counter_mixed_prng_macros.svh"

module rc4cm_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_ready,
    input wire logic                        i_operation,
    input wire logic                        i_key_last,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [rc4cm_pkg::RES_W-1:0] o_random_word
);

    logic in_acc;
    logic ld_mid;
    logic eng_start;
    assign in_acc    = i_in_valid && o_in_ready;
    assign ld_mid    = in_acc && i_operation == rc4cm_pkg::OP_LOAD && !i_key_last;
    assign eng_start = in_acc && (i_operation == rc4cm_pkg::OP_GEN || i_key_last);

    // after a non-final key word the input is ready again in the next cycle
    `RC4CM_ASSERT_NXT(a_load_quick, ld_mid, o_in_ready)
    // generate and final key word both occupy the engine
    `RC4CM_ASSERT_NXT(a_gen_busy, eng_start, !o_in_ready)
    // a new result only appears as the engine finishes a word
    `RC4CM_ASSERT_IMP(a_out_from_busy, $rose(o_out_valid), $past(!o_in_ready))
    // stalled result holds
    `RC4CM_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_random_word))

endmodule

bind rc4_counter_mixed_prng rc4cm_checker u_rc4cm_checker (.*);

`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// RC4 counter-mixed PRNG testbench
// Sends key words and generate requests with random gaps on both channels.
// A built-in keystream predictor follows every accepted word, and each
// returned keystream word is compared, in order, with its prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int SBOX_N       = 256;
    localparam int DROP_N       = 256;
    localparam int N_ITEMS      = 1600;
    localparam int DRAIN_CYCLES = 3 * (SBOX_N + DROP_N) + 64;
    localparam int DRAIN_LIMIT  = 20000;

    typedef struct {
        logic                        op;
        logic [rc4cm_pkg::KEY_W-1:0] word;
        logic                        last;
    } t_req;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic                        i_operation = rc4cm_pkg::OP_LOAD;
    logic [rc4cm_pkg::KEY_W-1:0] i_key_word = '0;
    logic                        i_key_last = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic [rc4cm_pkg::RES_W-1:0] o_random_word;

    rc4_counter_mixed_prng #(
        .SBOX_SIZE  (SBOX_N),
        .DROP_STEPS (DROP_N)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_key_word    (i_key_word),
        .i_key_last    (i_key_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_random_word (o_random_word)
    );

    always #5 i_clk = ~i_clk;

    // keystream predictor state
    logic [7:0]       ks_sbox [SBOX_N];
    logic [7:0]       ks_key [256];
    int unsigned      ks_words;
    int unsigned      ks_i;
    int unsigned      ks_j;
    logic [63:0]      ks_ctr;

    t_req                        pending_reqs [$];
    logic [rc4cm_pkg::RES_W-1:0] keystream_due [$];
    int unsigned      total_reqs = 0;
    int unsigned      taken_reqs = 0;
    int unsigned      fail_count = 0;

    bit               in_fire = 1'b0;
    bit               out_fire = 1'b0;
    bit               in_burst = 1'b0;
    bit               out_burst = 1'b0;
    int unsigned      in_gap = 0;
    int unsigned      out_stall = 0;
    int unsigned      out_pause;
    t_req             drv_req;
    logic [rc4cm_pkg::RES_W-1:0] want_word;

    function automatic void report_error(string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("@%0t: %s", $time, msg);
        end
    endfunction

    function automatic void ks_swap();
        logic [7:0] t;
        t = ks_sbox[ks_i];
        ks_sbox[ks_i] = ks_sbox[ks_j];
        ks_sbox[ks_j] = t;
    endfunction

    function automatic void ks_swap_step(int unsigned extra);
        ks_i = (ks_i + 1) % SBOX_N;
        ks_j = (ks_j + ks_sbox[ks_i] + extra) % SBOX_N;
        ks_swap();
    endfunction

    function automatic void ks_reset();
        for (int n = 0; n < SBOX_N; n++) begin
            ks_sbox[n] = n[7:0];
        end
        for (int n = 0; n < 256; n++) begin
            ks_key[n] = '0;
        end
        ks_words = 0;
        ks_i = 0;
        ks_j = 0;
        ks_ctr = '0;
    endfunction

    function automatic void ks_schedule();
        int unsigned fill;
        fill = ks_words * 8;
        if (fill > SBOX_N) begin
            fill = SBOX_N;
        end
        // stretch a short key with the byte LCG
        for (int unsigned n = fill; n < SBOX_N; n++) begin
            ks_key[n] = 8'(ks_key[n - 1] * rc4cm_pkg::LCG_MUL + rc4cm_pkg::LCG_INC);
        end
        for (int n = 0; n < SBOX_N; n++) begin
            ks_sbox[n] = n[7:0];
        end
        ks_j = 0;
        for (int unsigned n = 0; n < SBOX_N; n++) begin
            ks_i = n;
            ks_j = (ks_j + ks_sbox[n] + ks_key[n]) % SBOX_N;
            ks_swap();
        end
        ks_i = 0;
        ks_j = 0;
        ks_ctr = '0;
        for (int n = 0; n < DROP_N; n++) begin
            ks_swap_step(0);
        end
        ks_words = 0;
    endfunction

    function automatic void ks_apply(logic op, logic [rc4cm_pkg::KEY_W-1:0] w, logic last);
        logic [63:0]                 c;
        logic [rc4cm_pkg::RES_W-1:0] r;
        int unsigned                 idx;
        if (op == rc4cm_pkg::OP_LOAD) begin
            for (int unsigned n = 0; n < 8; n++) begin
                if (ks_words * 8 + n < SBOX_N) begin
                    ks_key[ks_words * 8 + n] = w[8 * n +: 8];
                end
            end
            if (ks_words < 63) begin
                ks_words++;
            end
            if (last) begin
                ks_schedule();
            end
        end else begin
            ks_ctr = ks_ctr + 64'd1;
            c = ks_ctr;
            r = '0;
            for (int n = 0; n < rc4cm_pkg::GEN_MIX_STEPS; n++) begin
                ks_swap_step(32'(c[7:0]));
                c = c >> 8;
            end
            for (int n = 0; n < rc4cm_pkg::GEN_STEPS - rc4cm_pkg::GEN_MIX_STEPS; n++) begin
                ks_swap_step(0);
                idx = (ks_sbox[ks_i] + ks_sbox[ks_j]) % SBOX_N;
                r[8 * n +: 8] = ks_sbox[idx];
            end
            keystream_due.push_back(r);
        end
    endfunction

    function automatic logic [rc4cm_pkg::KEY_W-1:0] rand_key_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void push_req(logic op, logic [rc4cm_pkg::KEY_W-1:0] w, logic last);
        t_req rq;
        rq.op = op;
        rq.word = w;
        rq.last = last;
        pending_reqs.push_back(rq);
    endfunction

    function automatic void push_gen();
        push_req(rc4cm_pkg::OP_GEN, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
    endfunction

    // close = 0 leaves the key open, to be continued by a later key
    function automatic void push_key(int unsigned nw, bit close);
        for (int unsigned k = 0; k < nw; k++) begin
            push_req(rc4cm_pkg::OP_LOAD, rand_key_word(), close && (k == nw - 1));
            if (k != nw - 1 && $urandom_range(0, 11) == 0) begin
                push_gen();
            end
        end
    endfunction

    function automatic int unsigned pick_gap(bit burst);
        int unsigned r;
        if (burst) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // driver: inputs change on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_fire) begin
                if (in_gap > 0) begin
                    i_in_valid <= 1'b0;
                    in_gap <= in_gap - 1;
                end else if (pending_reqs.size() > 0) begin
                    drv_req = pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                    i_operation <= drv_req.op;
                    i_key_word <= drv_req.word;
                    i_key_last <= drv_req.last;
                    if ($urandom_range(0, 63) == 0) begin
                        in_burst = !in_burst;
                    end
                    in_gap <= pick_gap(in_burst);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end

            if (out_fire) begin
                if ($urandom_range(0, 63) == 0) begin
                    out_burst = !out_burst;
                end
                out_pause = pick_gap(out_burst);
                i_out_ready <= (out_pause == 0);
                out_stall <= (out_pause == 0) ? 0 : out_pause - 1;
            end else if (out_stall > 0) begin
                i_out_ready <= 1'b0;
                out_stall <= out_stall - 1;
            end else begin
                i_out_ready <= out_burst || ($urandom_range(0, 7) != 0);
            end
        end
    end

    // monitor: handshakes sampled on the rising edge
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        out_fire <= i_rst_n && o_out_valid && i_out_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                ks_apply(i_operation, i_key_word, i_key_last);
                taken_reqs++;
            end
            if (o_out_valid === 1'b1 && i_out_ready) begin
                if (keystream_due.size() == 0) begin
                    report_error($sformatf("unexpected word: got %h", o_random_word));
                end else begin
                    want_word = keystream_due.pop_front();
                    if (o_random_word !== want_word) begin
                        report_error($sformatf("word mismatch: expected %h, got %h",
                                               want_word, o_random_word));
                    end
                end
            end
        end
    end

    initial begin
        int unsigned waited;
        int unsigned nw;
        ks_reset();

        // generate on the reset S-box; last flag set during generate
        push_req(rc4cm_pkg::OP_GEN, '0, 1'b0);
        push_req(rc4cm_pkg::OP_GEN, '1, 1'b1);
        // one- and two-word keys, rest filled by the LCG
        push_req(rc4cm_pkg::OP_LOAD, '1, 1'b1);
        push_req(rc4cm_pkg::OP_GEN, '0, 1'b0);
        push_req(rc4cm_pkg::OP_LOAD, '0, 1'b1);
        push_req(rc4cm_pkg::OP_GEN, '1, 1'b1);
        push_req(rc4cm_pkg::OP_LOAD, 64'h0123_4567_89AB_CDEF, 1'b0);
        push_req(rc4cm_pkg::OP_LOAD, 64'hFEDC_BA98_7654_3210, 1'b1);
        push_req(rc4cm_pkg::OP_GEN, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        push_req(rc4cm_pkg::OP_GEN, 64'h5555_5555_5555_5555, 1'b1);
        // generate in the middle of a key
        push_req(rc4cm_pkg::OP_LOAD, 64'h8000_0000_0000_0001, 1'b0);
        push_req(rc4cm_pkg::OP_GEN, '0, 1'b0);
        push_req(rc4cm_pkg::OP_LOAD, 64'h7FFF_FFFF_FFFF_FFFE, 1'b1);
        push_req(rc4cm_pkg::OP_GEN, '1, 1'b0);

        // exact fill, then a key running past the S-box and the word count
        push_key(32, 1'b1);
        push_gen();
        push_gen();
        push_key(70, 1'b1);
        push_gen();
        push_gen();
        while (pending_reqs.size() < N_ITEMS) begin
            case ($urandom_range(0, 99)) inside
                [0:5]: begin
                    case ($urandom_range(0, 9)) inside
                        [0:6]: nw = $urandom_range(1, 4);
                        [7:8]: nw = $urandom_range(5, 40);
                        default: nw = $urandom_range(60, 80);
                    endcase
                    push_key(nw, 1'b1);
                end
                [6:7]: push_key($urandom_range(1, 6), 1'b0);
                default: push_gen();
            endcase
        end
        total_reqs = pending_reqs.size();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (taken_reqs < total_reqs) @(posedge i_clk);
        waited = 0;
        while (keystream_due.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (keystream_due.size() > 0) begin
            report_error($sformatf("%0d keystream words never arrived",
                                   keystream_due.size()));
        end

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
